@@ sv/mfat_pkg.sv @@
// ----------------------------------------------------------------------------
// mfat_pkg
// shared command and outcome codes for the multicast fragment ack tracker
// ----------------------------------------------------------------------------
package mfat_pkg;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_DISCARD = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OUT_NOTHING  = 3'd0,
        OUT_SENT     = 3'd1,
        OUT_HELD     = 3'd2,
        OUT_IGNORED  = 3'd3,
        OUT_COMPLETE = 3'd4,
        OUT_FAILED   = 3'd5
    } t_outcome;

    // entry flag bit positions
    localparam int FLAG_TIMEOUT = 0;
    localparam int FLAG_BCAST   = 1;
    localparam int FLAG_HOLD    = 2;

    localparam logic [7:0] MAX_TRIES_RESET = 8'd5;
    localparam logic [7:0] TRIES_SAT       = 8'd255;
    localparam logic [6:0] FCOUNT_SAT      = 7'd127;

endpackage

@@ sv/mfat_ram.sv @@
// ----------------------------------------------------------------------------
// mfat_ram
// simple dual-port ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module mfat_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ sv/multicast_fragment_ack_tracker_core.sv @@
// ----------------------------------------------------------------------------
// multicast_fragment_ack_tracker_core
// per-fragment pending-receiver tracking for one multicast message
// ----------------------------------------------------------------------------
//
// channel    direction  handshake                      payload
// --------   ---------  -----------------------------  ---------------------------
// command    in         start high while busy low      i_command .. i_hold_first_try
// result     out        o_result_valid, one cycle      o_outcome .. o_faulty_fragments
// config     in         i_cfg_valid and o_cfg_ready    i_cfg_data (max_tries)
//
// add, ack and timeout do one ram read, then the modify and write back
// discard sweeps the entry ram one entry per cycle
// a failure found by an add or timeout reads its entry first, then runs the same sweep
// reset is synchronous; the entry ram is not cleared, per-entry valid bits guard it
// the result is registered and shown for one cycle; the receiver cannot stall it
// config is always ready; the block does not enforce it, so write config only while the block is idle
// ----------------------------------------------------------------------------
module multicast_fragment_ack_tracker_core #(
    parameter int FRAGMENTS = 64,
    parameter int NODES     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command transfer
    input  logic                start,
    output logic                busy,
    input  mfat_pkg::t_cmd      i_command,
    input  logic [31:0]         i_message_number,
    input  logic [5:0]          i_fragment_index,
    input  logic                i_is_end,
    input  logic [15:0]         i_target_mask,
    input  logic                i_target_known,
    input  logic [3:0]          i_node_index,
    input  logic                i_node_known,
    input  logic                i_may_time_out,
    input  logic                i_is_broadcast_type,
    input  logic                i_hold_first_try,
    // result transfer
    output logic                o_result_valid,
    output mfat_pkg::t_outcome  o_outcome,
    output logic [5:0]          o_out_fragment,
    output logic [15:0]         o_send_mask,
    output logic [7:0]          o_try_count,
    output logic                o_arm_timer,
    output logic                o_cancel_timer,
    output logic [15:0]         o_faulty_nodes,
    output logic [6:0]          o_faulty_fragments,
    // config transfer
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);

    import mfat_pkg::*;

    localparam int AW = $clog2(FRAGMENTS);
    localparam int CW = AW + 1;
    localparam int EW = NODES + 11;   // {flags[2:0], tries[7:0], mask}

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WALK = 3'b100
    } t_state;

    // control state
    t_state               r_state, n_state;
    logic [FRAGMENTS-1:0] r_valid, n_valid;
    logic [FRAGMENTS-1:0] r_wait, n_wait;
    logic                 r_latched, n_latched;
    logic [31:0]          r_cur_msg, n_cur_msg;
    logic                 r_end_known, n_end_known;
    logic [7:0]           r_max_tries;
    logic                 r_o_valid, n_o_valid;

    // captured command
    t_cmd                 r_cmd;
    logic [31:0]          r_msg;
    logic [5:0]           r_frag;
    logic                 r_is_end;
    logic [15:0]          r_target;
    logic                 r_target_known;
    logic [3:0]           r_node;
    logic                 r_node_known;
    logic                 r_mto;
    logic                 r_bcast;
    logic                 r_hold;

    // sweep state
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_walk_fail, n_walk_fail;
    logic [NODES-1:0]     r_uni, n_uni;
    logic [6:0]           r_fcnt, n_fcnt;
    logic [7:0]           r_try, n_try;

    // result registers
    t_outcome             r_o_outcome, n_o_outcome;
    logic [5:0]           r_o_frag, n_o_frag;
    logic [15:0]          r_o_send, n_o_send;
    logic [7:0]           r_o_try, n_o_try;
    logic                 r_o_arm, n_o_arm;
    logic                 r_o_cancel, n_o_cancel;
    logic [15:0]          r_o_fnodes, n_o_fnodes;
    logic [6:0]           r_o_ffrags, n_o_ffrags;

    // ram ports
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    // decoded read data and helpers
    logic [NODES-1:0]     rd_mask;
    logic [7:0]           rd_tries;
    logic [2:0]           rd_flags;
    logic [AW-1:0]        fa;
    logic [AW-1:0]        pi;
    logic                 in_range;
    logic [NODES-1:0]     nbit;
    logic [FRAGMENTS-1:0] fsel;
    logic                 any_valid;
    logic [NODES-1:0]     b_mask;
    logic [7:0]           b_tries;
    logic [2:0]           b_flags;
    logic [7:0]           t1;
    logic [NODES-1:0]     nm;

    mfat_ram #(
        .WIDTH (EW),
        .DEPTH (FRAGMENTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_mask   = ram_rdata[NODES-1:0];
    assign rd_tries  = ram_rdata[NODES+7:NODES];
    assign rd_flags  = ram_rdata[NODES+10:NODES+8];
    assign fa        = AW'(r_frag);
    assign pi        = AW'(r_cnt - CW'(1));
    assign in_range  = 32'(r_frag) < FRAGMENTS;
    assign nbit      = NODES'(1) << r_node;
    assign fsel      = {{(FRAGMENTS-1){1'b0}}, 1'b1} << fa;
    assign any_valid = |r_valid;

    // in idle the read address comes straight off the command port
    assign ram_raddr = (r_state == S_IDLE) ? AW'(i_fragment_index) : r_cnt[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_wait      = r_wait;
        n_latched   = r_latched;
        n_cur_msg   = r_cur_msg;
        n_end_known = r_end_known;
        n_cnt       = r_cnt;
        n_walk_fail = r_walk_fail;
        n_uni       = r_uni;
        n_fcnt      = r_fcnt;
        n_try       = r_try;
        n_o_valid   = 1'b0;
        n_o_outcome = OUT_NOTHING;
        n_o_frag    = 6'd0;
        n_o_send    = 16'd0;
        n_o_try     = 8'd0;
        n_o_arm     = 1'b0;
        n_o_cancel  = 1'b0;
        n_o_fnodes  = 16'd0;
        n_o_ffrags  = 7'd0;
        ram_we      = 1'b0;
        ram_waddr   = fa;
        ram_wdata   = ram_rdata;
        b_mask      = r_valid[fa] ? rd_mask : NODES'(r_target);
        b_tries     = r_valid[fa] ? rd_tries : 8'd0;
        b_flags     = r_valid[fa] ? rd_flags : {r_hold, r_bcast, r_mto};
        t1          = (b_tries == TRIES_SAT) ? TRIES_SAT : b_tries + 8'd1;
        nm          = rd_mask & ~nbit;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_command == CMD_DISCARD) begin
                        n_state     = S_WALK;
                        n_cnt       = '0;
                        n_walk_fail = 1'b0;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                n_state   = S_IDLE;
                n_o_valid = 1'b1;
                n_o_frag  = r_frag;
                if (!in_range) begin
                    n_o_outcome = OUT_IGNORED;
                end else begin
                    case (r_cmd)
                        CMD_ADD: begin
                            if (r_latched && r_cur_msg != r_msg) begin
                                n_o_outcome = OUT_IGNORED;
                            end else if (!r_valid[fa] && !r_target_known) begin
                                // unknown target on a new entry fails the message
                                n_latched   = 1'b1;
                                n_cur_msg   = r_msg;
                                n_state     = S_WALK;
                                n_cnt       = '0;
                                n_walk_fail = 1'b1;
                                n_uni       = '0;
                                n_fcnt      = 7'd0;
                                n_try       = 8'd0;
                                n_o_valid   = 1'b0;
                            end else begin
                                n_latched  = 1'b1;
                                n_cur_msg  = r_msg;
                                n_valid[fa] = 1'b1;
                                n_wait[fa] = 1'b1;
                                ram_we     = 1'b1;
                                ram_wdata  = {b_flags, t1, b_mask};
                                n_o_try    = t1;
                                n_o_arm    = 1'b1;
                                if (b_flags[FLAG_HOLD] && t1 == 8'd1) begin
                                    n_o_outcome = OUT_HELD;
                                end else begin
                                    n_o_outcome = OUT_SENT;
                                    n_o_send    = 16'(b_mask);
                                end
                                if (r_is_end) begin
                                    n_end_known = 1'b1;
                                end
                            end
                        end

                        CMD_ACK: begin
                            if (!r_latched || r_cur_msg != r_msg || !r_valid[fa] ||
                                !r_node_known) begin
                                n_o_outcome = OUT_IGNORED;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = {rd_flags, rd_tries, nm};
                                n_o_try   = rd_tries;
                                if (nm == '0) begin
                                    n_wait[fa] = 1'b0;
                                    n_o_cancel = 1'b1;
                                    if (any_valid && (r_wait & ~fsel) == '0 && r_end_known) begin
                                        n_valid     = '0;
                                        n_wait      = '0;
                                        n_latched   = 1'b0;
                                        n_cur_msg   = 32'd0;
                                        n_end_known = 1'b0;
                                        n_o_outcome = OUT_COMPLETE;
                                    end
                                end
                            end
                        end

                        CMD_TIMEOUT: begin
                            if (!r_valid[fa]) begin
                                n_o_outcome = OUT_IGNORED;
                            end else if (rd_mask == '0) begin
                                n_o_try    = rd_tries;
                                n_wait[fa] = 1'b0;
                                if (any_valid && (r_wait & ~fsel) == '0 && r_end_known) begin
                                    n_valid     = '0;
                                    n_wait      = '0;
                                    n_latched   = 1'b0;
                                    n_cur_msg   = 32'd0;
                                    n_end_known = 1'b0;
                                    n_o_outcome = OUT_COMPLETE;
                                    n_o_cancel  = 1'b1;
                                end
                            end else if (rd_flags[FLAG_TIMEOUT] && rd_tries > r_max_tries) begin
                                // try limit passed: sweep for the failure report
                                n_state     = S_WALK;
                                n_cnt       = '0;
                                n_walk_fail = 1'b1;
                                n_uni       = '0;
                                n_fcnt      = 7'd0;
                                n_try       = rd_tries;
                                n_o_valid   = 1'b0;
                            end else begin
                                n_wait[fa] = 1'b1;
                                ram_we     = 1'b1;
                                ram_wdata  = {rd_flags, t1, rd_mask};
                                n_o_try    = t1;
                                n_o_arm    = 1'b1;
                                if (rd_flags[FLAG_HOLD] && t1 == 8'd1) begin
                                    n_o_outcome = OUT_HELD;
                                end else begin
                                    n_o_outcome = OUT_SENT;
                                    n_o_send    = 16'(rd_mask);
                                end
                            end
                        end

                        default: begin
                            n_o_outcome = OUT_IGNORED;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // read entry r_cnt, process entry r_cnt-1 from the ram output
                n_cnt = r_cnt + CW'(1);
                if (r_cnt != '0) begin
                    if (r_walk_fail) begin
                        if (r_valid[pi] && rd_mask != '0) begin
                            n_uni  = r_uni | rd_mask;
                            n_fcnt = (r_fcnt == FCOUNT_SAT) ? FCOUNT_SAT : r_fcnt + 7'd1;
                        end
                    end else if (r_valid[pi] && rd_flags[FLAG_BCAST]) begin
                        ram_we    = 1'b1;
                        ram_waddr = pi;
                        ram_wdata = {rd_flags, rd_tries, nm};
                        if (nm == '0) begin
                            n_wait[pi] = 1'b0;
                        end
                    end
                end
                if (r_cnt == CW'(FRAGMENTS)) begin
                    n_state   = S_IDLE;
                    n_o_valid = 1'b1;
                    if (r_walk_fail) begin
                        n_o_outcome = OUT_FAILED;
                        n_o_frag    = r_frag;
                        n_o_try     = r_try;
                        n_o_cancel  = 1'b1;
                        n_o_fnodes  = 16'(n_uni);
                        n_o_ffrags  = n_fcnt;
                        n_valid     = '0;
                        n_wait      = '0;
                        n_latched   = 1'b0;
                        n_cur_msg   = 32'd0;
                        n_end_known = 1'b0;
                    end else if (any_valid && n_wait == '0 && r_end_known) begin
                        n_o_outcome = OUT_COMPLETE;
                        n_o_cancel  = 1'b1;
                        n_valid     = '0;
                        n_wait      = '0;
                        n_latched   = 1'b0;
                        n_cur_msg   = 32'd0;
                        n_end_known = 1'b0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_wait      <= '0;
            r_latched   <= 1'b0;
            r_cur_msg   <= 32'd0;
            r_end_known <= 1'b0;
            r_max_tries <= MAX_TRIES_RESET;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_wait      <= n_wait;
            r_latched   <= n_latched;
            r_cur_msg   <= n_cur_msg;
            r_end_known <= n_end_known;
            r_o_valid   <= n_o_valid;
            if (i_cfg_valid) begin
                r_max_tries <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd          <= i_command;
            r_msg          <= i_message_number;
            r_frag         <= i_fragment_index;
            r_is_end       <= i_is_end;
            r_target       <= i_target_mask;
            r_target_known <= i_target_known;
            r_node         <= i_node_index;
            r_node_known   <= i_node_known;
            r_mto          <= i_may_time_out;
            r_bcast        <= i_is_broadcast_type;
            r_hold         <= i_hold_first_try;
            r_uni          <= '0;
            r_fcnt         <= 7'd0;
        end else begin
            r_uni  <= n_uni;
            r_fcnt <= n_fcnt;
        end
        r_cnt       <= n_cnt;
        r_walk_fail <= n_walk_fail;
        r_try       <= n_try;
        r_o_outcome <= n_o_outcome;
        r_o_frag    <= n_o_frag;
        r_o_send    <= n_o_send;
        r_o_try     <= n_o_try;
        r_o_arm     <= n_o_arm;
        r_o_cancel  <= n_o_cancel;
        r_o_fnodes  <= n_o_fnodes;
        r_o_ffrags  <= n_o_ffrags;
    end

    assign busy               = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_result_valid     = r_o_valid;
    assign o_outcome          = r_o_outcome;
    assign o_out_fragment     = r_o_frag;
    assign o_send_mask        = r_o_send;
    assign o_try_count        = r_o_try;
    assign o_arm_timer        = r_o_arm;
    assign o_cancel_timer     = r_o_cancel;
    assign o_faulty_nodes     = r_o_fnodes;
    assign o_faulty_fragments = r_o_ffrags;

    // a result only follows command work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> $past(r_state != S_IDLE))
        else $error("result without command work");

    // complete or fail leaves an empty table
    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_outcome == OUT_COMPLETE || r_o_outcome == OUT_FAILED))
        |-> (r_valid == '0 && !r_latched && !r_end_known))
        else $error("table not cleared after complete or fail");

    // only existing entries can wait for acks
    a_wait_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait & ~r_valid) == '0)
        else $error("waiting fragment without entry");

    // an accepted command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

endmodule
